// ----- sv/bbdc_pkg.sv -----
package bbdc_pkg;

  // q15 one and its 16 bit code
  localparam int unsigned Q_ONE = 32768;
  localparam logic [15:0] Q_ONE_Q15 = 16'(Q_ONE);

  // field widths
  localparam int unsigned DATA_W = 16;
  localparam int unsigned MIN_W = 13;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned OUT_DATA_W = 5 * DATA_W;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY = 8'd1;
  localparam logic [DATA_W-1:0] PERIOD_RST = 16'd54400;
  localparam logic [MIN_W-1:0] MIN_DUTY_RST = 13'd544;

  // reciprocal 2^30 / s: 16 quotient bits, two restoring steps per stage
  localparam int unsigned RECIP_STEPS = 2;
  localparam int unsigned RECIP_STAGES = DATA_W / RECIP_STEPS;
  localparam logic [DATA_W-1:0] RECIP_REM_INIT = 16'(Q_ONE / 2);

  // item data that rides alongside the reciprocal
  typedef struct packed {
    logic              boost_mode;
    logic [DATA_W-1:0] buck_q15;
  } bbdc_side_t;

endpackage

// ----- sv/bbdc_recip.sv -----
module bbdc_recip (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [bbdc_pkg::DATA_W-1:0]         in_div,
  input  bbdc_pkg::bbdc_side_t                in_side,
  output logic                                out_vld,
  output logic [bbdc_pkg::DATA_W-1:0]         out_quo,
  output bbdc_pkg::bbdc_side_t                out_side
);

  localparam int unsigned ST = bbdc_pkg::RECIP_STAGES;
  localparam int unsigned W = bbdc_pkg::DATA_W;

  logic [ST-1:0] vld_r;
  logic [W-1:0]  rem_r  [ST];
  logic [W-1:0]  div_r  [ST];
  logic [W-1:0]  quo_r  [ST];
  bbdc_pkg::bbdc_side_t side_r [ST];

  for (genvar k = 0; k < ST; k++) begin : g_stg
    logic                 vld_src;
    logic [W-1:0]         rem_src;
    logic [W-1:0]         div_src;
    logic [W-1:0]         quo_src;
    bbdc_pkg::bbdc_side_t side_src;
    logic [W-1:0]         rem_nxt;
    logic [W-1:0]         quo_nxt;

    if (k == 0) begin : g_first
      assign vld_src  = in_vld;
      assign rem_src  = bbdc_pkg::RECIP_REM_INIT;
      assign div_src  = in_div;
      assign quo_src  = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign div_src  = div_r[k-1];
      assign quo_src  = quo_r[k-1];
      assign side_src = side_r[k-1];
    end

    // restoring steps, remainder stays below the divisor
    always_comb begin : p_step
      logic [W:0] trial;
      rem_nxt = rem_src;
      quo_nxt = quo_src;
      for (int j = 0; j < int'(bbdc_pkg::RECIP_STEPS); j++) begin
        trial = {rem_nxt, 1'b0};
        if (trial >= {1'b0, div_src}) begin
          rem_nxt = W'(trial - {1'b0, div_src});
          quo_nxt = {quo_nxt[W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[W-1:0];
          quo_nxt = {quo_nxt[W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
      if (en) begin
        rem_r[k]  <= rem_nxt;
        div_r[k]  <= div_src;
        quo_r[k]  <= quo_nxt;
        side_r[k] <= side_src;
      end
    end
  end

  assign out_vld  = vld_r[ST-1];
  assign out_quo  = quo_r[ST-1];
  assign out_side = side_r[ST-1];

endmodule

// ----- sv/buck_boost_duty_to_compare_core.sv -----
// channel | dir | handshake          | payload
// cfg     | in  | cfg_valid/ready    | cfg_index (0 period, 1 min duty), cfg_data
// in      | in  | in_tvalid/tready   | in_tdata: ratio_q15
// out     | out | out_tvalid/tready  | out_tdata: compare one..three, buck, boost duty
//                                     | out_tuser: boost_mode
//
// one ratio accepted per cycle while the output is not stalled; a ratio passes 3 front stages,
// 8 reciprocal stages (2 quotient bits each), 3 multiply/sum stages, output reg
// rst_n is synchronous: clears all valid bits, loads config defaults
// a stalled output freezes the whole pipe; one skid entry still takes the
// next input transfer, so in_tready never depends on out_tready
module buck_boost_duty_to_compare_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // config writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bbdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bbdc_pkg::DATA_W-1:0]           cfg_data,
  // ratio stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [bbdc_pkg::DATA_W-1:0]           in_tdata,   // [15:0] ratio_q15
  // compare stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [15:0] compare_one, [31:16] compare_two, [47:32] compare_three,
  // [63:48] buck_duty_q15, [79:64] boost_duty_q15
  output logic [bbdc_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tuser   // [0] boost_mode
);

  localparam int unsigned W = bbdc_pkg::DATA_W;

  // config registers
  logic [W-1:0]                 period_r;
  logic [bbdc_pkg::MIN_W-1:0]   min_r;
  logic [W-1:0]                 min16;
  logic [W-1:0]                 window;

  // flow control
  logic         en;
  logic         skid_vld_r;
  logic [W-1:0] skid_data_r;
  logic         src_vld;
  logic [W-1:0] src_ratio;
  logic         src_boost;

  // stage 1: mode and multiplier operand
  logic         s1_vld_r;
  logic         s1_boost_r;
  logic [W-1:0] s1_opnd_r;

  // stage 2: scaled ratio product
  logic [2*W-1:0] win_prod;
  logic           s2_vld_r;
  logic           s2_boost_r;
  logic [W-1:0]   s2_mul_r;

  // stage 3: buck duty and reciprocal divisor
  logic                 s3_vld_r;
  logic [W-1:0]         s3_div_r;
  bbdc_pkg::bbdc_side_t s3_side_r;
  logic [W-1:0]         scaled;
  logic [W-1:0]         buck_duty;

  // reciprocal output
  logic                 rc_vld;
  logic [W-1:0]         rc_quo;
  bbdc_pkg::bbdc_side_t rc_side;

  // stage 4: boost duty and overlap
  logic         s4_vld_r;
  logic         s4_mode_r;
  logic [W-1:0] s4_buck_r;
  logic [W-1:0] s4_bst_r;
  logic [W-1:0] s4_diff_r;

  // stage 5: period products
  logic [2*W-1:0] buck_prod;
  logic [2*W-1:0] bst_prod;
  logic [2*W-1:0] span_prod;
  logic           s5_vld_r;
  logic           s5_mode_r;
  logic [W-1:0]   s5_buck_r;
  logic [W-1:0]   s5_bst_r;
  logic [W-1:0]   s5_c1_r;
  logic [W-1:0]   s5_bterm_r;
  logic [W:0]     s5_span_r;

  // stage 6: limited span, second compare
  logic [W-1:0] span_lim;
  logic         s6_vld_r;
  logic         s6_mode_r;
  logic [W-1:0] s6_buck_r;
  logic [W-1:0] s6_bst_r;
  logic [W-1:0] s6_c1_r;
  logic [W-1:0] s6_c2_r;
  logic [W-1:0] s6_bterm_r;

  // output register
  logic         out_vld_r;
  logic         out_mode_r;
  logic [W-1:0] out_c1_r;
  logic [W-1:0] out_c2_r;
  logic [W-1:0] out_c3_r;
  logic [W-1:0] out_buck_r;
  logic [W-1:0] out_bst_r;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= bbdc_pkg::PERIOD_RST;
      min_r    <= bbdc_pkg::MIN_DUTY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bbdc_pkg::CFG_PERIOD:   period_r <= cfg_data;
        bbdc_pkg::CFG_MIN_DUTY: min_r    <= cfg_data[bbdc_pkg::MIN_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign min16 = {{(W - bbdc_pkg::MIN_W){1'b0}}, min_r};
  // duty window between the two margins, never below 16386
  assign window = bbdc_pkg::Q_ONE_Q15 - {min16[W-2:0], 1'b0};

  // ---------------------------------------------------------- skid / enable
  // whole pipe moves unless a result sits unclaimed at the output
  assign en        = !out_vld_r || out_tready;
  assign in_tready = !skid_vld_r;
  assign src_vld   = skid_vld_r || in_tvalid;
  assign src_ratio = skid_vld_r ? skid_data_r : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (en) begin
      skid_vld_r <= 1'b0;
    end else if (in_tvalid && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
    if (!skid_vld_r) begin
      skid_data_r <= in_tdata;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // ratio above one: excess over one goes to the multiplier
  assign src_boost = src_ratio > bbdc_pkg::Q_ONE_Q15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= src_vld;
    end
    if (en) begin
      s1_boost_r <= src_boost;
      s1_opnd_r  <= src_boost ? {1'b0, src_ratio[W-2:0]} : src_ratio;
    end
  end

  // ---------------------------------------------------------------- stage 2
  assign win_prod = s1_opnd_r * window;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_boost_r <= s1_boost_r;
      s2_mul_r   <= win_prod[2*W-2:W-1];   // q15 product, low 16 bits
    end
  end

  // ---------------------------------------------------------------- stage 3
  // boost: scaled lands in [one + min, 2 - min) so the reciprocal stays in range
  // buck: duty is one minus the scaled ratio, idle leg keeps the margin
  always_comb begin
    if (s2_boost_r) begin
      scaled    = s2_mul_r + bbdc_pkg::Q_ONE_Q15 + min16;
      buck_duty = min16;
    end else begin
      scaled    = s2_mul_r + min16;
      buck_duty = bbdc_pkg::Q_ONE_Q15 - scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
    if (en) begin
      // buck items run through the divider with a harmless divisor
      s3_div_r             <= s2_boost_r ? scaled : '1;
      s3_side_r.boost_mode <= s2_boost_r;
      s3_side_r.buck_q15   <= buck_duty;
    end
  end

  // ------------------------------------------------------------- reciprocal
  bbdc_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_vld_r),
    .in_div   (s3_div_r),
    .in_side  (s3_side_r),
    .out_vld  (rc_vld),
    .out_quo  (rc_quo),
    .out_side (rc_side)
  );

  // ---------------------------------------------------------------- stage 4
  // overlap = one - buck - boost; in boost mode that is quotient - margin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= rc_vld;
    end
    if (en) begin
      s4_mode_r <= rc_side.boost_mode;
      s4_buck_r <= rc_side.buck_q15;
      if (rc_side.boost_mode) begin
        s4_bst_r  <= bbdc_pkg::Q_ONE_Q15 - rc_quo;
        s4_diff_r <= rc_quo - min16;
      end else begin
        s4_bst_r  <= min16;
        s4_diff_r <= bbdc_pkg::Q_ONE_Q15 - rc_side.buck_q15 - min16;
      end
    end
  end

  // ---------------------------------------------------------------- stage 5
  assign buck_prod = s4_buck_r * period_r;
  assign bst_prod  = s4_bst_r * period_r;
  assign span_prod = s4_diff_r * period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
    if (en) begin
      s5_mode_r  <= s4_mode_r;
      s5_buck_r  <= s4_buck_r;
      s5_bst_r   <= s4_bst_r;
      s5_c1_r    <= buck_prod[2*W-2:W-1];
      s5_bterm_r <= bst_prod[2*W-2:W-1];
      s5_span_r  <= span_prod[2*W-1:W-1];
    end
  end

  // ---------------------------------------------------------------- stage 6
  // span never exceeds one period
  assign span_lim = (s5_span_r > {1'b0, period_r}) ? period_r : s5_span_r[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
    if (en) begin
      s6_mode_r  <= s5_mode_r;
      s6_buck_r  <= s5_buck_r;
      s6_bst_r   <= s5_bst_r;
      s6_c1_r    <= s5_c1_r;
      s6_c2_r    <= s5_c1_r + {1'b0, span_lim[W-1:1]};
      s6_bterm_r <= s5_bterm_r;
    end
  end

  // ----------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s6_vld_r;
    end
    if (en) begin
      out_mode_r <= s6_mode_r;
      out_c1_r   <= s6_c1_r;
      out_c2_r   <= s6_c2_r;
      out_c3_r   <= s6_c2_r + s6_bterm_r;   // wraps at 16 bits
      out_buck_r <= s6_buck_r;
      out_bst_r  <= s6_bst_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_bst_r, out_buck_r, out_c3_r, out_c2_r, out_c1_r};
  assign out_tuser  = out_mode_r;

  // ------------------------------------------------------------- assertions
  // pipe comes out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipe not empty after reset");

  // skid only fills behind a stalled result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_tvalid)
    else $error("skid holds an item with no result waiting");

  // once the output moves, the skid entry enters the pipe
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && out_tready |=> !skid_vld_r && in_tready)
    else $error("skid entry not drained on output transfer");

endmodule
